[src/bm25_pkg.sv]
// Package: shared constants and types for the BM25 field term scorer.
`timescale 1ns / 1ps
`default_nettype none
package bm25_pkg;
  localparam int SCORE_FRAC_BITS_DEF = 16;
  localparam int MANT_FRAC = 30;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOTAL_DOCS = 3'd0,
    REG_AVG_LENGTH = 3'd1,
    REG_K1         = 3'd2,
    REG_B          = 3'd3,
    REG_W_TITLE    = 3'd4,
    REG_W_CONTENT  = 3'd5,
    REG_W_DESC     = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_TITLE   = 2'd0,
    KIND_CONTENT = 2'd1,
    KIND_DESC    = 2'd2,
    KIND_OTHER   = 2'd3
  } kind_t;
endpackage
`default_nettype wire

[src/bm25_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module bm25_div #(
  parameter int NW = 64,
  parameter int QW = 64
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [QW-1:0] num,
  input  wire logic [NW-1:0] den,
  output logic               busy,
  output logic [QW-1:0]      quot
);
  localparam int CW = $clog2(QW + 1);
  logic [NW-1:0] rem;
  logic [QW-1:0] nsh;
  logic [CW-1:0] cnt;
  logic [NW:0]   trial;

  // one shift-subtract step on the partial remainder
  always_comb begin
    trial = {rem, nsh[QW-1]} - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(QW);
      rem  <= '0;
      nsh  <= num;
      quot <= '0;
    end else if (busy) begin
      if (!trial[NW]) begin
        rem  <= trial[NW-1:0];
        quot <= {quot[QW-2:0], 1'b1};
      end else begin
        rem  <= {rem[NW-2:0], nsh[QW-1]};
        quot <= {quot[QW-2:0], 1'b0};
      end
      nsh <= {nsh[QW-2:0], 1'b0};
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) busy <= 1'b0;
    end
  end
endmodule
`default_nettype wire

[src/bm25_log2.sv]
// Serial log2 unit: MSB search then one squaring per fraction bit.
`timescale 1ns / 1ps
`default_nettype none
module bm25_log2 #(
  parameter int FRAC = bm25_pkg::SCORE_FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [25:0] x,
  output logic             busy,
  output logic [FRAC+4:0]  result
);
  localparam int MF = bm25_pkg::MANT_FRAC;
  localparam int CW = $clog2(FRAC + 27);
  typedef enum logic [1:0] {L_IDLE, L_NORM, L_SQ} lstate_t;
  lstate_t st;
  logic [25:0] xs;
  logic [25:0] xin;
  logic [4:0]  e;
  logic [MF:0] m;
  logic [CW-1:0] cnt;
  logic [FRAC-1:0] frac;
  logic [2*MF+1:0] sq;
  logic [MF+1:0] mn;

  // truncated square of the mantissa
  always_comb begin
    sq = m * m;
    mn = sq[2*MF+1:MF];
  end

  assign busy = (st != L_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= L_IDLE;
    end else begin
      case (st)
        L_IDLE: if (start) begin
          xs <= x; xin <= x; e <= 5'd0; st <= L_NORM;
        end
        // walk to the MSB one bit per cycle
        L_NORM: begin
          if (xs[25:1] != 25'd0) begin
            xs <= {1'b0, xs[25:1]};
            e  <= e + 1'b1;
          end else begin
            m <= (MF+1)'(xin) << (MF - 32'(e));
            cnt <= CW'(FRAC);
            frac <= '0;
            st <= L_SQ;
          end
        end
        L_SQ: begin
          if (mn[MF+1]) begin
            m <= mn[MF+1:1];
            frac <= {frac[FRAC-2:0], 1'b1};
          end else begin
            m <= mn[MF:0];
            frac <= {frac[FRAC-2:0], 1'b0};
          end
          cnt <= cnt - 1'b1;
          if (cnt == CW'(1)) st <= L_IDLE;
        end
        default: st <= L_IDLE;
      endcase
    end
  end

  assign result = {e, frac};
endmodule
`default_nettype wire

[src/bm25_field_term_scorer.sv]
// Top level: BM25 field term scorer with serial log, divide and accumulate.
// One word is worked at a time. A word with zero term frequency, or any word
// while the corpus size is zero, skips the log, divide, multiply, round and
// saturate steps. Any other word takes two log2 passes, on 2(N-df)+1 and
// 2df+1 (each an MSB walk one bit per cycle, then one squaring per fraction
// bit), then two divider passes of F + 49 quotient bits, one per cycle, then
// the multiply, round, saturate, weight and output steps. The log and divider
// units set the time. The result waits in an output register; the next word
// is taken while it waits, and a new result is held back until the old one
// is gone.
`timescale 1ns / 1ps
`default_nettype none
module bm25_field_term_scorer #(
  parameter int SCORE_FRAC_BITS = bm25_pkg::SCORE_FRAC_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [bm25_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bm25_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [63:0]  s_tdata,  // term_freq, field_length, doc_freq
  input  wire logic [1:0]   s_tuser,  // kind
  input  wire logic         s_tlast,  // last_term
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [135:0]      m_tdata,  // term_score, weighted_score, doc_total, title_matches
  output logic              m_tlast   // doc_end
);
  localparam int F = SCORE_FRAC_BITS;
  localparam int LW = F + 5;
  localparam int DQW = 49 + F;
  localparam logic [31:0] LN2_Q32_S = bm25_pkg::LN2_Q32;

  typedef enum logic [3:0] {
    S_IDLE, S_LOGA, S_LOGB, S_IDF, S_RATIO, S_LEN, S_DEN, S_DIV,
    S_MUL, S_SAT, S_WMUL, S_ACC, S_OUT
  } state_t;
  state_t st;

  // configuration
  logic [23:0] total_docs;
  logic [31:0] avg_length;
  logic [15:0] k1;
  logic [16:0] b;
  logic [15:0] w_title, w_content, w_desc;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_docs <= '0; avg_length <= 32'd256; k1 <= 16'd4915; b <= 17'd49152;
      w_title <= 16'd256; w_content <= 16'd256; w_desc <= 16'd256;
    end else if (cfg_we) begin
      case (bm25_pkg::cfg_reg_t'(cfg_index))
        bm25_pkg::REG_TOTAL_DOCS: total_docs <= cfg_data[23:0];
        bm25_pkg::REG_AVG_LENGTH: avg_length <= cfg_data;
        bm25_pkg::REG_K1:         k1 <= cfg_data[15:0];
        bm25_pkg::REG_B:          b <= cfg_data[16:0];
        bm25_pkg::REG_W_TITLE:    w_title <= cfg_data[15:0];
        bm25_pkg::REG_W_CONTENT:  w_content <= cfg_data[15:0];
        bm25_pkg::REG_W_DESC:     w_desc <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // captured word
  logic [15:0] tf;
  logic [23:0] fl, df;
  logic [1:0]  kind;
  logic        last;
  logic        zero_case;

  // serial units
  logic lg_start, lg_busy, dv_start, dv_busy;
  logic [25:0] lg_x;
  logic [LW-1:0] lg_res, log_a;
  logic [DQW-1:0] dv_num;
  logic [63:0] dv_den;
  logic [DQW-1:0] dv_q;

  bm25_log2 #(.FRAC(F)) u_log (
    .clk(clk), .rst(rst), .start(lg_start), .x(lg_x),
    .busy(lg_busy), .result(lg_res)
  );

  bm25_div #(.NW(64), .QW(DQW)) u_div (
    .clk(clk), .rst(rst), .start(dv_start), .num(dv_num), .den(dv_den),
    .busy(dv_busy), .quot(dv_q)
  );

  // working registers
  logic signed [LW:0]  dlog;
  logic signed [63:0]  prod;
  logic signed [47:0]  idf;
  logic [31:0] ratio;
  logic [47:0] lenterm;
  logic [63:0] den;
  logic [DQW-1:0] numq;
  logic        div_pass;
  logic [31:0] q_int;
  logic signed [31:0] score;
  logic signed [47:0] weighted;
  logic signed [47:0] running_total;
  logic [7:0]  title_cnt;
  logic        started;
  logic [15:0] wsel;
  logic [23:0] df_c;
  logic [16:0] bq;
  logic signed [47:0] tsat;
  logic [7:0] tcnt;

  // magnitude round helper: shift right s, ties away from zero
  function automatic logic signed [63:0] rnd(input logic signed [63:0] v,
                                             input int s);
    logic [63:0] mag;
    begin
      mag = v[63] ? 64'(-v) : 64'(v);
      mag = (mag + (64'd1 << (s - 1))) >> s;
      rnd = v[63] ? -$signed(mag) : $signed(mag);
    end
  endfunction

  logic [48:0] tsum;
  logic signed [31:0] sat_s;
  always_comb begin
    tsum = {running_total[47], running_total} + {weighted[47], weighted};
    wsel = (kind == bm25_pkg::KIND_TITLE) ? w_title :
           (kind == bm25_pkg::KIND_CONTENT) ? w_content :
           (kind == bm25_pkg::KIND_DESC) ? w_desc : 16'd256;
    df_c = (df > total_docs) ? total_docs : df;
    lg_x = (st == S_IDLE || st == S_LOGA) ?
           {1'b0, (total_docs - df_c), 1'b1} : {1'b0, df_c, 1'b1};
    dv_num = div_pass ? numq : (DQW'(fl) << 24);
    dv_den = div_pass ? den : ((avg_length == 32'd0) ? 64'd1 : 64'(avg_length));
    sat_s = (prod > 64'sh7FFFFFFF) ? 32'sh7FFFFFFF :
            (prod < -64'sh80000000) ? -32'sh80000000 : prod[31:0];
  end

  assign s_tready = (st == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      m_tvalid <= 1'b0;
      running_total <= '0;
      title_cnt <= '0;
      lg_start <= 1'b0;
      dv_start <= 1'b0;
      started <= 1'b0;
      div_pass <= 1'b0;
    end else begin
      // one-cycle start pulses for the serial units
      lg_start <= ((st == S_LOGA && !zero_case) || st == S_LOGB) && !started;
      dv_start <= (st == S_RATIO || st == S_DIV) && !started;
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (st)
        S_IDLE: if (s_tvalid && s_tready) begin
          tf <= s_tdata[15:0]; fl <= s_tdata[39:16]; df <= s_tdata[63:40];
          kind <= s_tuser; last <= s_tlast;
          zero_case <= (s_tdata[15:0] == 16'd0) || (total_docs == 24'd0);
          started <= 1'b0;
          st <= S_LOGA;
        end
        S_LOGA: begin
          if (zero_case) begin
            score <= '0; st <= S_WMUL;
          end else if (!started) begin
            started <= 1'b1;
          end else if (!lg_start && !lg_busy) begin
            log_a <= lg_res; started <= 1'b0; st <= S_LOGB;
          end
        end
        S_LOGB: begin
          if (!started) begin
            started <= 1'b1;
          end else if (!lg_start && !lg_busy) begin
            dlog <= $signed({1'b0, log_a}) - $signed({1'b0, lg_res});
            started <= 1'b0; st <= S_IDF;
          end
        end
        S_IDF: begin
          prod <= 64'(dlog) * $signed({1'b0, LN2_Q32_S});
          st <= S_RATIO;
        end
        S_RATIO: begin
          if (!started) begin
            idf <= 48'(rnd(prod, 32));
            div_pass <= 1'b0; started <= 1'b1;
          end else if (!dv_start && !dv_busy) begin
            ratio <= (dv_q > DQW'(32'hFFFFFFFF)) ? 32'hFFFFFFFF : dv_q[31:0];
            started <= 1'b0; st <= S_LEN;
          end
        end
        S_LEN: begin
          lenterm <= 48'((((65'd65536 - 65'(bq)) << 16) + 65'(bq) * 65'(ratio)) >> 16);
          st <= S_DEN;
        end
        S_DEN: begin
          den <= (64'(tf) << 28) + 64'(k1) * 64'(lenterm);
          numq <= (DQW'(tf) * (DQW'(k1) + DQW'(4096))) << (16 + F);
          st <= S_DIV;
        end
        S_DIV: begin
          if (!started) begin
            div_pass <= 1'b1; started <= 1'b1;
          end else if (!dv_start && !dv_busy) begin
            q_int <= dv_q[31:0]; started <= 1'b0; st <= S_MUL;
          end
        end
        S_MUL: begin
          prod <= $signed(idf[31:0]) * $signed({1'b0, q_int});
          st <= S_SAT;
        end
        S_SAT: begin
          prod <= rnd(prod, F);
          st <= S_ACC;
        end
        S_ACC: begin
          score <= sat_s;
          st <= S_WMUL;
        end
        S_WMUL: begin
          weighted <= 48'(rnd(64'(score) * $signed({48'd0, wsel}), 8));
          st <= S_OUT;
        end
        S_OUT: if (!m_tvalid) begin
          m_tvalid <= 1'b1;
          m_tdata[31:0] <= score;
          m_tdata[79:32] <= weighted;
          m_tdata[127:80] <= tsat;
          m_tdata[135:128] <= tcnt;
          m_tlast <= last;
          running_total <= last ? 48'sd0 : tsat;
          title_cnt <= last ? 8'd0 : tcnt;
          st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    bq = (b > 17'd65536) ? 17'd65536 : b;
    tsat = (tsum[48] != tsum[47]) ?
           (tsum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}}) : tsum[47:0];
    tcnt = (kind == bm25_pkg::KIND_TITLE && tf != 16'd0 && title_cnt != 8'hFF) ?
           title_cnt + 1'b1 : title_cnt;
  end

  // numerator already scaled by 2^F in the second divider pass
  // (the numq value is shifted by 16 + F before the pass starts)

  a_busy_units: assert property (@(posedge clk) disable iff (rst)
    !(lg_busy && dv_busy)) else $error("log and divide overlap");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("result changed while waiting");
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !$past(m_tvalid) && m_tlast) |-> running_total == 48'sd0)
    else $error("total not cleared after last");
endmodule
`default_nettype wire
